FILE: src/bcadc_pkg.sv
// ----------------------------------------------------------------------------
// Battery charge gauge package
// Shared widths, codes, control structs and the breakpoint curves used by the
// sequencer and the datapath of the battery charge gauge.
// ----------------------------------------------------------------------------
package bcadc_pkg;

   // Default and fixed sizes
   localparam int MAX_POINTS_DEFAULT = 8;
   localparam int CURVE_POINTS       = 8;
   localparam int PT_W               = $clog2(CURVE_POINTS);
   localparam int COUNT_W            = $clog2(CURVE_POINTS + 1);
   localparam int RAW_W              = 16;
   localparam int MV_W               = 20;
   localparam int LEVEL_W            = 16;
   localparam int CHEM_W             = 2;
   localparam int BP_W               = 14;

   // Millivolt scaling: mv = raw * 9175 / 1000 = raw * 367 / 40, truncated.
   // The divide by 40 drops three bits and then divides by 5 with a
   // reciprocal multiply, which is exact for any 22-bit value.
   localparam int SCALE_W            = 14;
   localparam logic [SCALE_W-1:0] MV_SCALE_NUM = 14'd367;
   localparam int MV_PRE_SHIFT       = 3;
   localparam int MV_RECIP_SHIFT     = 22;
   localparam int MV_RECIP_W         = 20;
   localparam logic [MV_RECIP_W-1:0] MV_RECIP = 20'd838861;

   // Shared multiplier and restoring divider
   localparam int MUL_W              = 22;
   localparam int PROD_W             = 2 * MUL_W;
   localparam int DIVIDEND_W         = 30;
   localparam int DIVISOR_W          = 10;
   localparam int REM_W              = DIVISOR_W + 1;
   localparam int DIV_STEPS          = DIVIDEND_W;
   localparam int STEP_W             = $clog2(DIV_STEPS);

   typedef enum logic [CHEM_W-1:0] {
      CHEM_LIFEPO4 = 2'd0,
      CHEM_LIPO    = 2'd1,
      CHEM_NIMH    = 2'd2,
      CHEM_UNKNOWN = 2'd3
   } chem_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SCALE_MV,
      ST_CHECK,
      ST_SEARCH,
      ST_MUL_SEG,
      ST_DIV_SEG,
      ST_INTERP,
      ST_DONE
   } state_type;

   typedef enum logic [2:0] {
      OP_NONE,
      OP_MUL_MV,
      OP_DIV_STEP,
      OP_MV_STORE,
      OP_MUL_SEG,
      OP_LVL_INTERP,
      OP_LVL_ZERO,
      OP_LVL_LAST
   } dp_op_type;

   typedef struct packed {
      dp_op_type       op;
      logic [PT_W-1:0] idx;
   } ctrl_type;

   typedef struct packed {
      logic mv_low;    // voltage below the first breakpoint plus one millivolt
      logic mv_below;  // voltage below the breakpoint after the selected one
   } status_type;

   // Number of breakpoints in each curve.
   function automatic logic [COUNT_W-1:0] curve_count(input chem_type chem);
      logic [COUNT_W-1:0] cnt;
      unique case (chem)
         CHEM_LIFEPO4: cnt = 4'd5;
         CHEM_LIPO:    cnt = 4'd8;
         CHEM_NIMH:    cnt = 4'd5;
         default:      cnt = 4'd0;
      endcase
      return cnt;
   endfunction

   // Breakpoint voltage in millivolts.
   function automatic logic [BP_W-1:0] curve_mv(input chem_type chem,
                                                input logic [PT_W-1:0] idx);
      logic [BP_W-1:0] mv;
      mv = '0;
      unique case (chem)
         CHEM_LIFEPO4: begin
            unique case (idx)
               3'd0:    mv = 14'd5650;
               3'd1:    mv = 14'd6413;
               3'd2:    mv = 14'd6652;
               3'd3:    mv = 14'd6707;
               3'd4:    mv = 14'd6760;
               default: mv = '0;
            endcase
         end
         CHEM_LIPO: begin
            unique case (idx)
               3'd0:    mv = 14'd7300;
               3'd1:    mv = 14'd7350;
               3'd2:    mv = 14'd7400;
               3'd3:    mv = 14'd7500;
               3'd4:    mv = 14'd7600;
               3'd5:    mv = 14'd7700;
               3'd6:    mv = 14'd7800;
               3'd7:    mv = 14'd8400;
               default: mv = '0;
            endcase
         end
         CHEM_NIMH: begin
            unique case (idx)
               3'd0:    mv = 14'd6300;
               3'd1:    mv = 14'd6600;
               3'd2:    mv = 14'd7200;
               3'd3:    mv = 14'd7800;
               3'd4:    mv = 14'd8400;
               default: mv = '0;
            endcase
         end
         default: mv = '0;
      endcase
      return mv;
   endfunction

   // Charge level at a breakpoint in Q1.15.
   function automatic logic [LEVEL_W-1:0] curve_level(input chem_type chem,
                                                      input logic [PT_W-1:0] idx);
      logic [LEVEL_W-1:0] lvl;
      lvl = '0;
      unique case (chem)
         CHEM_LIFEPO4: begin
            unique case (idx)
               3'd0:    lvl = 16'd0;
               3'd1:    lvl = 16'd2130;
               3'd2:    lvl = 16'd13763;
               3'd3:    lvl = 16'd24904;
               3'd4:    lvl = 16'd32768;
               default: lvl = '0;
            endcase
         end
         CHEM_LIPO: begin
            unique case (idx)
               3'd0:    lvl = 16'd0;
               3'd1:    lvl = 16'd3277;
               3'd2:    lvl = 16'd6554;
               3'd3:    lvl = 16'd13107;
               3'd4:    lvl = 16'd16384;
               3'd5:    lvl = 16'd19661;
               3'd6:    lvl = 16'd26214;
               3'd7:    lvl = 16'd32768;
               default: lvl = '0;
            endcase
         end
         CHEM_NIMH: begin
            unique case (idx)
               3'd0:    lvl = 16'd0;
               3'd1:    lvl = 16'd8192;
               3'd2:    lvl = 16'd16384;
               3'd3:    lvl = 16'd24576;
               3'd4:    lvl = 16'd32768;
               default: lvl = '0;
            endcase
         end
         default: lvl = '0;
      endcase
      return lvl;
   endfunction

endpackage

FILE: src/bcadc_dp.sv
// ----------------------------------------------------------------------------
// Battery charge gauge datapath
// One shared 22x22 multiplier, a one-bit-per-cycle restoring divider for the
// interpolation, the breakpoint compares and the result registers.
// ----------------------------------------------------------------------------
module bcadc_dp (
   input  logic                           clock,
   input  bcadc_pkg::ctrl_type            ctrl,
   input  bcadc_pkg::chem_type            chem,
   input  logic [bcadc_pkg::RAW_W-1:0]    raw_reading,
   output bcadc_pkg::status_type          status,
   output logic [bcadc_pkg::MV_W-1:0]     voltage_mv,
   output logic [bcadc_pkg::LEVEL_W-1:0]  charge_level
);

   logic [bcadc_pkg::DIVIDEND_W-1:0] dividend_ff, dividend_in;
   logic [bcadc_pkg::REM_W-1:0]      rem_ff, rem_in;
   logic [bcadc_pkg::DIVISOR_W-1:0]  divisor_ff, divisor_in;
   logic [bcadc_pkg::MV_W-1:0]       mv_ff, mv_in;
   logic [bcadc_pkg::LEVEL_W-1:0]    level_ff, level_in;

   logic [bcadc_pkg::MUL_W-1:0]      mul_a, mul_b;
   logic [bcadc_pkg::PROD_W-1:0]     product;
   logic [bcadc_pkg::REM_W:0]        rem_shift;
   logic                             rem_ge;
   logic [bcadc_pkg::PT_W-1:0]       idx_next;
   logic [bcadc_pkg::BP_W-1:0]       x_lo, x_hi;
   logic [bcadc_pkg::LEVEL_W-1:0]    y_lo, y_hi;

   assign idx_next = ctrl.idx + bcadc_pkg::PT_W'(1);
   assign x_lo     = bcadc_pkg::curve_mv(chem, ctrl.idx);
   assign x_hi     = bcadc_pkg::curve_mv(chem, idx_next);
   assign y_lo     = bcadc_pkg::curve_level(chem, ctrl.idx);
   assign y_hi     = bcadc_pkg::curve_level(chem, idx_next);

   // Shared multiplier operands.
   always_comb begin
      unique case (ctrl.op)
         bcadc_pkg::OP_MUL_SEG: begin
            mul_a = bcadc_pkg::MUL_W'(y_hi - y_lo);
            mul_b = bcadc_pkg::MUL_W'(mv_ff - bcadc_pkg::MV_W'(x_lo));
         end
         bcadc_pkg::OP_MV_STORE: begin
            // Reading times 367 with the low three bits dropped, times 1/5.
            mul_a = dividend_ff[bcadc_pkg::MV_PRE_SHIFT +: bcadc_pkg::MUL_W];
            mul_b = bcadc_pkg::MUL_W'(bcadc_pkg::MV_RECIP);
         end
         default: begin
            mul_a = bcadc_pkg::MUL_W'(raw_reading);
            mul_b = bcadc_pkg::MUL_W'(bcadc_pkg::MV_SCALE_NUM);
         end
      endcase
   end

   assign product = mul_a * mul_b;

   // Restoring division step; quotient bits shift in behind the dividend.
   assign rem_shift = {rem_ff, dividend_ff[bcadc_pkg::DIVIDEND_W-1]};
   assign rem_ge    = rem_shift >= (bcadc_pkg::REM_W+1)'(divisor_ff);

   always_comb begin
      dividend_in = dividend_ff;
      rem_in      = rem_ff;
      divisor_in  = divisor_ff;
      mv_in       = mv_ff;
      level_in    = level_ff;
      unique case (ctrl.op)
         bcadc_pkg::OP_MUL_MV: begin
            dividend_in = bcadc_pkg::DIVIDEND_W'(product);
         end
         bcadc_pkg::OP_MUL_SEG: begin
            dividend_in = bcadc_pkg::DIVIDEND_W'(product);
            rem_in      = '0;
            divisor_in  = bcadc_pkg::DIVISOR_W'(x_hi - x_lo);
         end
         bcadc_pkg::OP_DIV_STEP: begin
            dividend_in = {dividend_ff[bcadc_pkg::DIVIDEND_W-2:0], rem_ge};
            rem_in      = rem_ge
                          ? bcadc_pkg::REM_W'(rem_shift - (bcadc_pkg::REM_W+1)'(divisor_ff))
                          : bcadc_pkg::REM_W'(rem_shift);
         end
         bcadc_pkg::OP_MV_STORE:
            mv_in    = product[bcadc_pkg::MV_RECIP_SHIFT +: bcadc_pkg::MV_W];
         bcadc_pkg::OP_LVL_INTERP: level_in = y_lo + bcadc_pkg::LEVEL_W'(dividend_ff);
         bcadc_pkg::OP_LVL_ZERO:   level_in = '0;
         bcadc_pkg::OP_LVL_LAST:   level_in = y_hi;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      dividend_ff <= dividend_in;
      rem_ff      <= rem_in;
      divisor_ff  <= divisor_in;
      mv_ff       <= mv_in;
      level_ff    <= level_in;
   end

   assign status.mv_low   = mv_ff < (bcadc_pkg::MV_W'(bcadc_pkg::curve_mv(chem, '0))
                                     + bcadc_pkg::MV_W'(1));
   assign status.mv_below = mv_ff < bcadc_pkg::MV_W'(x_hi);

   assign voltage_mv   = mv_ff;
   assign charge_level = level_ff;

endmodule

FILE: src/bcadc_ctrl.sv
// ----------------------------------------------------------------------------
// Battery charge gauge sequencer
// Steps the shared datapath through scaling, the segment search and the
// interpolation, and raises the result strobe.
// ----------------------------------------------------------------------------
module bcadc_ctrl #(
   parameter int MAX_POINTS = bcadc_pkg::MAX_POINTS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  bcadc_pkg::chem_type   chem,
   input  bcadc_pkg::status_type status,
   output bcadc_pkg::ctrl_type   ctrl,
   output logic                  busy,
   output logic                  done
);

   localparam int CNT_W = $clog2(MAX_POINTS + 1);
   localparam logic [bcadc_pkg::STEP_W-1:0] STEP_LAST =
      bcadc_pkg::STEP_W'(bcadc_pkg::DIV_STEPS - 1);

   bcadc_pkg::state_type state_ff, state_in;
   logic [CNT_W-1:0]                seg_ff, seg_in;
   logic [bcadc_pkg::STEP_W-1:0]    step_ff, step_in;
   logic [bcadc_pkg::COUNT_W-1:0]   count;
   logic [CNT_W-1:0]                n_pts;
   logic                            last_seg;
   logic                            div_last;

   // Points in use: the curve length, capped by the parameter.
   assign count    = bcadc_pkg::curve_count(chem);
   assign n_pts    = (int'(count) > MAX_POINTS) ? CNT_W'(MAX_POINTS) : CNT_W'(count);
   assign last_seg = ({1'b0, seg_ff} + (CNT_W+1)'(2)) >= {1'b0, n_pts};
   assign div_last = step_ff == STEP_LAST;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         bcadc_pkg::ST_IDLE:     if (start) state_in = bcadc_pkg::ST_SCALE_MV;
         bcadc_pkg::ST_SCALE_MV: state_in = bcadc_pkg::ST_CHECK;
         bcadc_pkg::ST_CHECK: begin
            if (chem == bcadc_pkg::CHEM_UNKNOWN || status.mv_low) begin
               state_in = bcadc_pkg::ST_DONE;
            end else begin
               state_in = bcadc_pkg::ST_SEARCH;
            end
         end
         bcadc_pkg::ST_SEARCH: begin
            priority if (status.mv_below) state_in = bcadc_pkg::ST_MUL_SEG;
            else if (last_seg)            state_in = bcadc_pkg::ST_DONE;
            else                          state_in = bcadc_pkg::ST_SEARCH;
         end
         bcadc_pkg::ST_MUL_SEG: state_in = bcadc_pkg::ST_DIV_SEG;
         bcadc_pkg::ST_DIV_SEG: if (div_last) state_in = bcadc_pkg::ST_INTERP;
         bcadc_pkg::ST_INTERP:  state_in = bcadc_pkg::ST_DONE;
         bcadc_pkg::ST_DONE:    state_in = bcadc_pkg::ST_IDLE;
         default:               state_in = bcadc_pkg::ST_IDLE;
      endcase
   end

   // Datapath operation and handshake outputs. On the last segment the
   // upper breakpoint of that segment is the last point of the curve.
   always_comb begin
      ctrl.op  = bcadc_pkg::OP_NONE;
      ctrl.idx = bcadc_pkg::PT_W'(seg_ff);
      busy     = state_ff != bcadc_pkg::ST_IDLE;
      done     = state_ff == bcadc_pkg::ST_DONE;
      unique case (state_ff)
         bcadc_pkg::ST_IDLE:     if (start) ctrl.op = bcadc_pkg::OP_MUL_MV;
         bcadc_pkg::ST_DIV_SEG:  ctrl.op = bcadc_pkg::OP_DIV_STEP;
         bcadc_pkg::ST_SCALE_MV: ctrl.op = bcadc_pkg::OP_MV_STORE;
         bcadc_pkg::ST_CHECK: begin
            if (chem == bcadc_pkg::CHEM_UNKNOWN || status.mv_low) begin
               ctrl.op = bcadc_pkg::OP_LVL_ZERO;
            end
         end
         bcadc_pkg::ST_SEARCH: begin
            if (!status.mv_below && last_seg) begin
               ctrl.op = bcadc_pkg::OP_LVL_LAST;
            end
         end
         bcadc_pkg::ST_MUL_SEG: ctrl.op = bcadc_pkg::OP_MUL_SEG;
         bcadc_pkg::ST_INTERP:  ctrl.op = bcadc_pkg::OP_LVL_INTERP;
         default: ;
      endcase
   end

   // Segment and division step counters.
   always_comb begin
      seg_in  = seg_ff;
      step_in = step_ff;
      unique case (state_ff)
         bcadc_pkg::ST_DIV_SEG: step_in = step_ff + bcadc_pkg::STEP_W'(1);
         bcadc_pkg::ST_CHECK:   seg_in  = '0;
         bcadc_pkg::ST_SEARCH: begin
            if (!status.mv_below && !last_seg) seg_in = seg_ff + CNT_W'(1);
         end
         default: step_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bcadc_pkg::ST_IDLE;
         seg_ff   <= '0;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         seg_ff   <= seg_in;
         step_ff  <= step_in;
      end
   end

endmodule

FILE: src/battery_charge_from_adc.sv
// ----------------------------------------------------------------------------
// Battery charge gauge from a raw ADC reading
// The result strobe comes soonest when the charge is zero and latest when the
// last segment is interpolated. A new request is taken only once the gauge
// is idle again; the time per request is set by the one-compare-per-cycle
// segment search and the shared restoring divider used for the interpolation.
// Reset (synchronous, active high) idles the sequencer and sets chemistry to
// LiFePO4. The receiver cannot stall: each result is shown for one cycle.
// ----------------------------------------------------------------------------
module battery_charge_from_adc #(
   parameter int MAX_POINTS = bcadc_pkg::MAX_POINTS_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   // Request channel
   input  logic                           start,
   output logic                           busy,
   input  logic [bcadc_pkg::RAW_W-1:0]    req_raw_reading,
   // Result channel
   output logic                           rsp_valid,
   output logic [bcadc_pkg::LEVEL_W-1:0]  rsp_charge_level,
   output logic [bcadc_pkg::MV_W-1:0]     rsp_voltage_mv,
   // Configuration
   input  logic                           csr_write_en,
   input  logic [bcadc_pkg::CHEM_W-1:0]   csr_write_data
);

   // The chemistry register selects which breakpoint curve is used. The user
   // must write it only while the gauge is idle, so the sequencer and datapath
   // can read it directly for the whole request; the block does not enforce it.
   bcadc_pkg::chem_type   chemistry_ff, chemistry_in;
   bcadc_pkg::ctrl_type   ctrl;
   bcadc_pkg::status_type status;
   logic                  done;

   always_comb begin
      chemistry_in = chemistry_ff;
      if (csr_write_en) begin
         chemistry_in = bcadc_pkg::chem_type'(csr_write_data);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chemistry_ff <= bcadc_pkg::CHEM_LIFEPO4;
      end else begin
         chemistry_ff <= chemistry_in;
      end
   end

   // The sequencer walks each request through these phases: scale the
   // reading (multiply by 367, drop three bits, then multiply by the
   // reciprocal of 5, since 9175/1000 is 367/40), test for an unknown
   // chemistry or a voltage at or below the first breakpoint, search the segments
   // one compare per cycle, then interpolate inside the segment found with
   // one more multiply and a divide one bit per cycle.
   bcadc_ctrl #(
      .MAX_POINTS (MAX_POINTS)
   ) u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .chem   (chemistry_ff),
      .status (status),
      .ctrl   (ctrl),
      .busy   (busy),
      .done   (done)
   );

   // The datapath holds the single multiplier shared by the millivolt
   // scaling and the interpolation, the divider, and the result registers.
   bcadc_dp u_dp (
      .clock        (clock),
      .ctrl         (ctrl),
      .chem         (chemistry_ff),
      .raw_reading  (req_raw_reading),
      .status       (status),
      .voltage_mv   (rsp_voltage_mv),
      .charge_level (rsp_charge_level)
   );

   // The result registers are final by the time the sequencer reaches its
   // done state, so the strobe is simply that state.
   assign rsp_valid = done;

   // A result strobe lasts exactly one cycle and the gauge goes idle after it.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> (!rsp_valid && !busy))
      else $error("result strobe held longer than one cycle");

   // An accepted request always makes the gauge busy on the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted request did not start the sequencer");

   // The charge level never exceeds full scale.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_charge_level <= bcadc_pkg::LEVEL_W'(32768)))
      else $error("charge level above full scale");

   // An unknown chemistry always reports zero charge.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && chemistry_ff == bcadc_pkg::CHEM_UNKNOWN) |->
         (rsp_charge_level == '0))
      else $error("unknown chemistry gave a nonzero charge level");

endmodule

FILE: tb/battery_charge_from_adc_test.sv
// ----------------------------------------------------------------------------
// Battery charge gauge testbench
// Sends raw ADC readings to the gauge under each battery chemistry. Every
// request is scored against an in-bench predictor of the millivolt scaling
// and the piecewise linear charge curve. The bench drives inputs on the
// falling edge, samples on the rising edge, and inserts random idle gaps.
// ----------------------------------------------------------------------------
module battery_charge_from_adc_test;
   timeunit 1ns;
   timeprecision 1ps;

   // One result of the gauge: charge in Q1.15 and voltage in millivolts.
   typedef struct packed {
      logic [bcadc_pkg::LEVEL_W-1:0] charge_level;
      logic [bcadc_pkg::MV_W-1:0]    voltage_mv;
   } gauge_reading_type;

   // Discharge curves of the three known chemistries. The breakpoints are in
   // millivolts and the levels are Q1.15 fractions of full charge. Unused
   // trailing entries are zero and never read.
   localparam int unsigned KNEE_COUNT [3] = '{5, 8, 5};
   localparam int unsigned KNEE_MV [3][8] = '{
      '{5650, 6413, 6652, 6707, 6760,    0,    0,    0},
      '{7300, 7350, 7400, 7500, 7600, 7700, 7800, 8400},
      '{6300, 6600, 7200, 7800, 8400,    0,    0,    0}
   };
   localparam int unsigned KNEE_LEVEL [3][8] = '{
      '{0,  2130, 13763, 24904, 32768,     0,     0,     0},
      '{0,  3277,  6554, 13107, 16384, 19661, 26214, 32768},
      '{0,  8192, 16384, 24576, 32768,     0,     0,     0}
   };

   // Wait after the last phase; well beyond the longest latency of the gauge.
   localparam int SETTLE_CYCLES = 100;
   localparam int RANDOM_PER_PHASE = 112;

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            start = 1'b0;
   logic                            busy;
   logic [bcadc_pkg::RAW_W-1:0]     req_raw_reading = '0;
   logic                            rsp_valid;
   logic [bcadc_pkg::LEVEL_W-1:0]   rsp_charge_level;
   logic [bcadc_pkg::MV_W-1:0]      rsp_voltage_mv;
   logic                            csr_write_en = 1'b0;
   logic [bcadc_pkg::CHEM_W-1:0]    csr_write_data = '0;

   // Readings waiting to be sent, and readings the gauge still owes us.
   logic [bcadc_pkg::RAW_W-1:0]     raw_backlog[$];
   gauge_reading_type               readings_due[$];

   // Chemistry the gauge is believed to hold; reset selects LiFePO4.
   bcadc_pkg::chem_type  chem_setting = bcadc_pkg::CHEM_LIFEPO4;
   int unsigned          idle_pct = 30;
   logic                 req_accepted = 1'b0;
   int                   mismatch_count = 0;

   battery_charge_from_adc dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_raw_reading  (req_raw_reading),
      .rsp_valid        (rsp_valid),
      .rsp_charge_level (rsp_charge_level),
      .rsp_voltage_mv   (rsp_voltage_mv),
      .csr_write_en     (csr_write_en),
      .csr_write_data   (csr_write_data)
   );

   // 10 ns clock.
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Predicts the gauge output for one raw reading under a chemistry. The
   // voltage is raw * 9.175 truncated; the charge is zero at or below the
   // first breakpoint, full at or above the last, and interpolated with a
   // floored division inside each segment. An unknown chemistry reads zero.
   function automatic gauge_reading_type predict_reading(
      input bcadc_pkg::chem_type chem,
      input logic [bcadc_pkg::RAW_W-1:0] raw);
      gauge_reading_type reading;
      longint unsigned   mv;
      longint unsigned   level;
      int unsigned       c;
      mv = (longint'(raw) * 9175) / 1000;
      level = 0;
      c = int'(chem);
      if (chem != bcadc_pkg::CHEM_UNKNOWN && mv >= KNEE_MV[c][0] + 1) begin
         // Past the last breakpoint unless a segment below catches it.
         level = KNEE_LEVEL[c][KNEE_COUNT[c] - 1];
         for (int i = KNEE_COUNT[c] - 2; i >= 0; i--) begin
            if (mv < KNEE_MV[c][i + 1]) begin
               level = KNEE_LEVEL[c][i]
                     + ((KNEE_LEVEL[c][i + 1] - KNEE_LEVEL[c][i]) * (mv - KNEE_MV[c][i]))
                       / (KNEE_MV[c][i + 1] - KNEE_MV[c][i]);
            end
         end
      end
      reading.charge_level = level[bcadc_pkg::LEVEL_W-1:0];
      reading.voltage_mv   = mv[bcadc_pkg::MV_W-1:0];
      return reading;
   endfunction

   // Smallest raw reading whose scaled voltage reaches the given millivolts.
   function automatic logic [bcadc_pkg::RAW_W-1:0] raw_reaching(
      input int unsigned target_mv);
      longint unsigned raw;
      raw = (longint'(target_mv) * 1000 + 9174) / 9175;
      if (raw > 65535) raw = 65535;
      return raw[bcadc_pkg::RAW_W-1:0];
   endfunction

   // Request driver. A request stays on the port until the gauge takes it;
   // after that, the next one goes out unless this cycle is picked as idle.
   // While idle the data lines carry noise that the gauge must ignore.
   always @(negedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (!start || req_accepted) begin
         if (raw_backlog.size() != 0 && $urandom_range(99) >= idle_pct) begin
            start           <= 1'b1;
            req_raw_reading <= raw_backlog.pop_front();
         end else begin
            start           <= 1'b0;
            req_raw_reading <= bcadc_pkg::RAW_W'($urandom);
         end
      end
   end

   // Result monitor. The response is scored before the request taken at the
   // same edge is queued, so a stray strobe can never match the new request.
   always @(posedge clock) begin
      gauge_reading_type wanted;
      if (!reset) begin
         if (rsp_valid) begin
            if (readings_due.size() == 0) begin
               $display("%0t: unexpected result charge_level=%0d voltage_mv=%0d",
                        $time, rsp_charge_level, rsp_voltage_mv);
               mismatch_count++;
            end else begin
               wanted = readings_due.pop_front();
               if (rsp_charge_level !== wanted.charge_level) begin
                  $display("%0t: charge_level expected %0d actual %0d",
                           $time, wanted.charge_level, rsp_charge_level);
                  mismatch_count++;
               end
               if (rsp_voltage_mv !== wanted.voltage_mv) begin
                  $display("%0t: voltage_mv expected %0d actual %0d",
                           $time, wanted.voltage_mv, rsp_voltage_mv);
                  mismatch_count++;
               end
            end
         end
         if (start && !busy) begin
            readings_due.push_back(predict_reading(chem_setting, req_raw_reading));
         end
      end
      req_accepted <= !reset && start && !busy;
   end

   // Blocks until every queued request has gone out and every result is in.
   // The check runs on the rising edge, where the driver never acts.
   task automatic wait_until_drained();
      do begin
         @(posedge clock);
      end while (raw_backlog.size() != 0 || start || readings_due.size() != 0);
   endtask

   // Writes the chemistry register while the gauge is idle.
   task automatic select_chemistry(input bcadc_pkg::chem_type chem);
      @(negedge clock);
      csr_write_en   <= 1'b1;
      csr_write_data <= chem;
      chem_setting    = chem;
      @(negedge clock);
      csr_write_en   <= 1'b0;
   endtask

   // Queues readings on both sides of the zero-charge and full-charge edges
   // of a curve, plus one point inside a middle segment.
   task automatic queue_curve_edges(input bcadc_pkg::chem_type chem);
      int unsigned c;
      c = int'(chem);
      raw_backlog.push_back(bcadc_pkg::RAW_W'(raw_reaching(KNEE_MV[c][0] + 1) - 1));
      raw_backlog.push_back(raw_reaching(KNEE_MV[c][0] + 1));
      raw_backlog.push_back(bcadc_pkg::RAW_W'(raw_reaching(KNEE_MV[c][2]) + 1));
      raw_backlog.push_back(
         bcadc_pkg::RAW_W'(raw_reaching(KNEE_MV[c][KNEE_COUNT[c] - 1]) - 1));
      raw_backlog.push_back(raw_reaching(KNEE_MV[c][KNEE_COUNT[c] - 1]));
   endtask

   // Most random readings land in the 4.6 V to 9.2 V band, where all three
   // curves have their segments; the rest span the full ADC range.
   task automatic queue_random_readings(input int count);
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(9) < 7) begin
            raw_backlog.push_back(16'($urandom_range(1000, 500)));
         end else begin
            raw_backlog.push_back(16'($urandom_range(65535)));
         end
      end
   endtask

   // Main sequence: reset, then eight phases, each with a chemistry. The first
   // phase runs with the reset value; the others rewrite the register while
   // the gauge is idle. The first visit to each curve opens with directed
   // readings; one phase runs with no idle cycles at all.
   initial begin
      bcadc_pkg::chem_type phase_chem[8];
      phase_chem = '{bcadc_pkg::CHEM_LIFEPO4, bcadc_pkg::CHEM_LIPO,
                     bcadc_pkg::CHEM_NIMH,    bcadc_pkg::CHEM_UNKNOWN,
                     bcadc_pkg::CHEM_LIFEPO4, bcadc_pkg::CHEM_NIMH,
                     bcadc_pkg::CHEM_LIPO,    bcadc_pkg::CHEM_UNKNOWN};
      repeat (2) @(negedge clock);
      reset <= 1'b0;

      for (int ph = 0; ph < 8; ph++) begin
         if (ph != 0) begin
            select_chemistry(phase_chem[ph]);
         end
         idle_pct = (ph == 5) ? 0 : 30;
         if (ph == 0) begin
            // ADC extremes and alternating bit patterns.
            raw_backlog.push_back(16'h0000);
            raw_backlog.push_back(16'hFFFF);
            raw_backlog.push_back(16'h5555);
            raw_backlog.push_back(16'hAAAA);
         end
         if (ph < 3) begin
            queue_curve_edges(phase_chem[ph]);
         end else if (ph == 3) begin
            // An unknown chemistry still reports the voltage.
            raw_backlog.push_back(16'hFFFF);
            raw_backlog.push_back(raw_reaching(7000));
         end
         queue_random_readings(RANDOM_PER_PHASE);
         wait_until_drained();
      end

      // Let any stray result show up before the verdict.
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   // Watchdog: a correct run needs well under a third of this time.
   initial begin
      #5_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

FILE: sim.f
src/bcadc_pkg.sv
src/bcadc_dp.sv
src/bcadc_ctrl.sv
src/battery_charge_from_adc.sv
tb/battery_charge_from_adc_test.sv
